@@ rtl/bss_pkg.sv @@
// Shared constants and types for the block sample statistics design.
// No dependencies; every other rtl file refers to it by scoped names.
`default_nettype none

package bss_pkg;

	localparam int SAMPLE_W      = 16;
	localparam int CFG_LEN_W     = 13;
	localparam int MAX_BLOCK_DEF = 4096;
	localparam int QUEUE_DEPTH   = 2;

	// APB register map
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_BLOCK_LENGTH = 1'b0;

	localparam logic [CFG_LEN_W-1:0] LEN_RESET = 13'd256;
	localparam logic signed [SAMPLE_W-1:0] MIN_RESET = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] MAX_RESET = 16'sh8000;

	// Occupancy of the block queue as seen by producer and consumer
	typedef struct packed {
		logic full;
		logic empty;
	} bss_qstat_t;

endpackage

`default_nettype wire

@@ rtl/bss_front.sv @@
// Sample accumulator: sum, sum of squares, min, max and block count.
// Uses bss_pkg; pushes one totals entry per completed block into bss_queue.
`default_nettype none

module bss_front #(
	parameter int MAX_BLOCK = bss_pkg::MAX_BLOCK_DEF
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic [bss_pkg::CFG_LEN_W-1:0]           blk_len,
	input  wire logic signed [bss_pkg::SAMPLE_W-1:0]     sample,
	input  wire logic                                    in_valid,
	output logic                                         in_stall,
	input  wire bss_pkg::bss_qstat_t                     qstat,
	output logic                                         push,
	output logic [3*bss_pkg::SAMPLE_W+3*$clog2(MAX_BLOCK+1)+30-1:0] entry
);

	localparam int CNT_W = $clog2(MAX_BLOCK + 1);
	localparam int SUM_W = bss_pkg::SAMPLE_W + CNT_W;
	localparam int SQ_W  = 30 + CNT_W;

	logic [CNT_W-1:0]                      cnt_q;
	logic signed [SUM_W-1:0]               sum_q;
	logic [SQ_W-1:0]                       sq_q;
	logic signed [bss_pkg::SAMPLE_W-1:0]   min_q;
	logic signed [bss_pkg::SAMPLE_W-1:0]   max_q;

	logic [31:0]                           len_raw;
	logic [31:0]                           len_clamp;
	logic [CNT_W-1:0]                      eff_len;
	logic [CNT_W-1:0]                      cnt_next;
	logic signed [31:0]                    sq_prod;
	logic signed [SUM_W-1:0]               sum_next;
	logic [SQ_W-1:0]                       sq_next;
	logic signed [bss_pkg::SAMPLE_W-1:0]   min_next;
	logic signed [bss_pkg::SAMPLE_W-1:0]   max_next;
	logic                                  accept;
	logic                                  done;

	// clamp the programmed length into 1..MAX_BLOCK
	assign len_raw   = 32'(blk_len);
	assign len_clamp = (len_raw == 32'd0) ? 32'd1 :
		(len_raw > 32'(MAX_BLOCK)) ? 32'(MAX_BLOCK) : len_raw;
	assign eff_len   = len_clamp[CNT_W-1:0];

	assign in_stall = qstat.full;
	assign accept   = in_valid && !in_stall;

	assign sq_prod  = sample * sample;
	assign sum_next = sum_q + SUM_W'(sample);
	assign sq_next  = sq_q + SQ_W'(sq_prod[30:0]);
	assign min_next = (sample < min_q) ? sample : min_q;
	assign max_next = (sample > max_q) ? sample : max_q;
	assign cnt_next = cnt_q + 1'b1;
	assign done     = (cnt_next >= eff_len);

	assign push  = accept && done;
	assign entry = {sum_next, sq_next, min_next, max_next, eff_len};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sum_q <= '0;
			sq_q  <= '0;
			min_q <= bss_pkg::MIN_RESET;
			max_q <= bss_pkg::MAX_RESET;
		end else if (accept) begin
			if (done) begin
				// block complete: clear for the next one
				cnt_q <= '0;
				sum_q <= '0;
				sq_q  <= '0;
				min_q <= bss_pkg::MIN_RESET;
				max_q <= bss_pkg::MAX_RESET;
			end else begin
				cnt_q <= cnt_next;
				sum_q <= sum_next;
				sq_q  <= sq_next;
				min_q <= min_next;
				max_q <= max_next;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/bss_queue.sv @@
// Small register queue of block totals between accumulator and finisher.
// Uses bss_pkg for depth and the occupancy struct.
`default_nettype none

module bss_queue #(
	parameter int W = 8
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire logic [W-1:0]    wdata,
	input  wire logic            pop,
	output logic [W-1:0]         rdata,
	output bss_pkg::bss_qstat_t  qstat
);

	localparam int DEPTH = bss_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int OCC_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [OCC_W-1:0] occ_q;
	logic             do_push;
	logic             do_pop;

	assign qstat.full  = (occ_q == OCC_W'(DEPTH));
	assign qstat.empty = (occ_q == '0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign rdata       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   occ_q <= occ_q + 1'b1;
				2'b01:   occ_q <= occ_q - 1'b1;
				default: occ_q <= occ_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/bss_back.sv @@
// Block finisher: shared bit-serial divider for mean and mean square,
// digit-by-digit square root, and the result register. Uses bss_pkg.
`default_nettype none

module bss_back #(
	parameter int MAX_BLOCK = bss_pkg::MAX_BLOCK_DEF
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire bss_pkg::bss_qstat_t                     qstat,
	input  wire logic [3*bss_pkg::SAMPLE_W+3*$clog2(MAX_BLOCK+1)+30-1:0] entry,
	output logic                                         pop,
	output logic                                         out_valid,
	input  wire logic                                    out_stall,
	output logic signed [bss_pkg::SAMPLE_W-1:0]          mean_value,
	output logic [bss_pkg::SAMPLE_W-1:0]                 rms_value,
	output logic signed [bss_pkg::SAMPLE_W-1:0]          min_value,
	output logic signed [bss_pkg::SAMPLE_W-1:0]          max_value,
	output logic [bss_pkg::SAMPLE_W-1:0]                 peak_to_peak
);

	localparam int SW     = bss_pkg::SAMPLE_W;
	localparam int CNT_W  = $clog2(MAX_BLOCK + 1);
	localparam int SUM_W  = SW + CNT_W;
	localparam int SQ_W   = 30 + CNT_W;
	localparam int DW     = SQ_W;
	localparam int RT_W   = (SQ_W + 1) / 2;
	localparam int SR_W   = RT_W + 2;
	localparam int STEP_W = $clog2(DW);

	// entry field offsets (LSB first: len, max, min, sq, sum)
	localparam int MAX_LO = CNT_W;
	localparam int MIN_LO = MAX_LO + SW;
	localparam int SQ_LO  = MIN_LO + SW;
	localparam int SUM_LO = SQ_LO + SQ_W;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DIV_M  = 3'd1;
	localparam logic [2:0] ST_DIV_S  = 3'd2;
	localparam logic [2:0] ST_ROOT   = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	logic [2:0]              state_q;
	logic [STEP_W-1:0]       step_q;
	logic [CNT_W-1:0]        len_q;
	logic [SQ_W-1:0]         sq_q;
	logic signed [SW-1:0]    min_q;
	logic signed [SW-1:0]    max_q;
	logic                    neg_q;
	logic [SW-1:0]           mean_q;
	logic [DW-1:0]           dvd_q;
	logic [CNT_W-1:0]        rem_q;
	logic [2*RT_W-1:0]       rad_q;
	logic [RT_W-1:0]         root_q;
	logic [SR_W-1:0]         srem_q;
	logic                    out_valid_q;

	logic signed [SUM_W-1:0] e_sum;
	logic [SUM_W-1:0]        e_mag;
	logic [CNT_W:0]          d_trial;
	logic                    d_ge;
	logic [CNT_W:0]          d_diff;
	logic [DW-1:0]           dvd_next;
	logic [SW-1:0]           q_low;
	logic [SR_W+1:0]         s_shift;
	logic [SR_W+1:0]         s_trial;
	logic                    s_ge;
	logic [SR_W+1:0]         s_diff;
	logic [RT_W-1:0]         root_next;
	logic                    last_step;
	logic                    out_free;

	assign e_sum = entry[SUM_LO +: SUM_W];
	assign e_mag = e_sum[SUM_W-1] ? SUM_W'(-e_sum) : SUM_W'(e_sum);

	// restoring division step, one quotient bit per cycle
	assign d_trial  = {rem_q, dvd_q[DW-1]};
	assign d_ge     = (d_trial >= {1'b0, len_q});
	assign d_diff   = d_trial - {1'b0, len_q};
	assign dvd_next = {dvd_q[DW-2:0], d_ge};
	assign q_low    = dvd_next[SW-1:0];

	// square root step, two radicand bits per cycle
	assign s_shift   = {srem_q, rad_q[2*RT_W-1 -: 2]};
	assign s_trial   = (SR_W + 2)'({root_q, 2'b01});
	assign s_ge      = (s_shift >= s_trial);
	assign s_diff    = s_shift - s_trial;
	assign root_next = {root_q[RT_W-2:0], s_ge};

	assign last_step = (step_q == '0);
	assign out_free  = !out_valid_q || !out_stall;
	assign pop       = (state_q == ST_IDLE) && !qstat.empty;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!qstat.empty) begin
						state_q <= ST_DIV_M;
						step_q  <= STEP_W'(DW - 1);
					end
				end
				ST_DIV_M: begin
					step_q <= last_step ? STEP_W'(DW - 1) : step_q - 1'b1;
					if (last_step) begin
						state_q <= ST_DIV_S;
					end
				end
				ST_DIV_S: begin
					step_q <= last_step ? STEP_W'(RT_W - 1) : step_q - 1'b1;
					if (last_step) begin
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					step_q <= step_q - 1'b1;
					if (last_step) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// raise valid as a result loads; drop it once taken with nothing new
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_FINISH) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				len_q <= entry[CNT_W-1:0];
				max_q <= entry[MAX_LO +: SW];
				min_q <= entry[MIN_LO +: SW];
				sq_q  <= entry[SQ_LO +: SQ_W];
				neg_q <= e_sum[SUM_W-1];
				dvd_q <= DW'(e_mag);
				rem_q <= '0;
			end
			ST_DIV_M: begin
				if (last_step) begin
					mean_q <= neg_q ? SW'(-q_low) : q_low;
					dvd_q  <= sq_q;
					rem_q  <= '0;
				end else begin
					dvd_q <= dvd_next;
					rem_q <= d_ge ? d_diff[CNT_W-1:0] : d_trial[CNT_W-1:0];
				end
			end
			ST_DIV_S: begin
				if (last_step) begin
					rad_q  <= (2 * RT_W)'(dvd_next);
					root_q <= '0;
					srem_q <= '0;
				end else begin
					dvd_q <= dvd_next;
					rem_q <= d_ge ? d_diff[CNT_W-1:0] : d_trial[CNT_W-1:0];
				end
			end
			ST_ROOT: begin
				rad_q  <= {rad_q[2*RT_W-3:0], 2'b00};
				root_q <= root_next;
				srem_q <= s_ge ? s_diff[SR_W-1:0] : s_shift[SR_W-1:0];
			end
			ST_FINISH: begin
				if (out_free) begin
					mean_value   <= mean_q;
					rms_value    <= root_q[SW-1:0];
					min_value    <= min_q;
					max_value    <= max_q;
					peak_to_peak <= SW'(max_q - min_q);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/block_sample_statistics.sv @@
// Top level of the block sample statistics engine: APB register, front
// accumulator, totals queue and back finisher. Uses bss_pkg, bss_front,
// bss_queue and bss_back.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_stall    sample
//   out      source     out_valid / out_stall  mean_value rms_value min_value
//                                              max_value peak_to_peak
//   apb      slave      psel penable pready    paddr pwrite pwdata prdata
//
// Samples are taken one per cycle while in_stall is low; the accumulator
// does one add, one 16x16 square and one add per transaction and is never
// the bottleneck. Each completed block costs the finisher two passes of
// the bit-serial divider and one pass of the two-bits-per-cycle root unit.
// The two-entry queue lets input run on while the finisher works; in_stall
// rises only when the queue is full, so short blocks hold the input while
// the finisher works through each block. Reset clears counters,
// accumulators and handshake state; block_length returns to 256. A stalled
// result holds in the output register while the finisher carries on with
// the next queued block.
`default_nettype none

module block_sample_statistics #(
	parameter int MAX_BLOCK = bss_pkg::MAX_BLOCK_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// APB configuration port
	input  wire logic                                  psel,
	input  wire logic                                  penable,
	input  wire logic                                  pwrite,
	input  wire logic [bss_pkg::APB_ADDR_W-1:0]        paddr,
	input  wire logic [bss_pkg::APB_DATA_W-1:0]        pwdata,
	output logic [bss_pkg::APB_DATA_W-1:0]             prdata,
	output logic                                       pready,
	// sample stream
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic signed [bss_pkg::SAMPLE_W-1:0]   sample,
	// result stream
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic signed [bss_pkg::SAMPLE_W-1:0]        mean_value,
	output logic [bss_pkg::SAMPLE_W-1:0]               rms_value,
	output logic signed [bss_pkg::SAMPLE_W-1:0]        min_value,
	output logic signed [bss_pkg::SAMPLE_W-1:0]        max_value,
	output logic [bss_pkg::SAMPLE_W-1:0]               peak_to_peak
);

	localparam int CNT_W = $clog2(MAX_BLOCK + 1);
	localparam int ENT_W = 3 * bss_pkg::SAMPLE_W + 3 * CNT_W + 30;

	logic [bss_pkg::CFG_LEN_W-1:0] blk_len_q;
	logic                          reg_sel;
	logic                          reg_wr;
	logic                          push;
	logic                          pop;
	logic [ENT_W-1:0]              wr_entry;
	logic [ENT_W-1:0]              rd_entry;
	bss_pkg::bss_qstat_t           qstat;

	// Register access: the only register sits at word 0; anything else
	// reads as zero and drops writes.
	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == bss_pkg::REG_BLOCK_LENGTH);
	assign reg_wr  = psel && penable && pwrite && reg_sel;
	assign prdata  = reg_sel ? bss_pkg::APB_DATA_W'(blk_len_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_len_q <= bss_pkg::LEN_RESET;
		end else if (reg_wr) begin
			blk_len_q <= pwdata[bss_pkg::CFG_LEN_W-1:0];
		end
	end

	// Front: accept each sample transaction and accumulate; push the
	// block totals on the sample that closes the block.
	bss_front #(
		.MAX_BLOCK (MAX_BLOCK)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.blk_len  (blk_len_q),
		.sample   (sample),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.qstat    (qstat),
		.push     (push),
		.entry    (wr_entry)
	);

	// Hold completed block totals until the finisher is free.
	bss_queue #(
		.W (ENT_W)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wr_entry),
		.pop    (pop),
		.rdata  (rd_entry),
		.qstat  (qstat)
	);

	// Back: divide, take the root and present the result transaction.
	bss_back #(
		.MAX_BLOCK (MAX_BLOCK)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.qstat        (qstat),
		.entry        (rd_entry),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.mean_value   (mean_value),
		.rms_value    (rms_value),
		.min_value    (min_value),
		.max_value    (max_value),
		.peak_to_peak (peak_to_peak)
	);

endmodule

`default_nettype wire
